FILE: src/dsu_pkg.sv
// Shared types and constants for the streaming unsigned decimal parser.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package dsu_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned POS_W   = 16;

  // Longest string offset tracked; the position stops counting here.
  localparam longint unsigned MAX_LEN = 64'd65535;
  localparam logic [POS_W-1:0] POS_LIMIT =
    (MAX_LEN > 64'd65535) ? 16'hFFFF : POS_W'(MAX_LEN);

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   end_pos;
    logic               overflow;
  } result_t;

endpackage

FILE: src/dsu_in_reg.sv
// Input register for one string byte with valid/ready handshake.
// Depends on dsu_pkg for the byte width.
`timescale 1ns / 1ps

module dsu_in_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dsu_pkg::CHAR_W-1:0] in_char_code,
  input  logic                       take,
  output logic                       byte_valid,
  output logic [dsu_pkg::CHAR_W-1:0] byte_code
);

  logic                       valid_r;
  logic                       valid_nxt;
  logic [dsu_pkg::CHAR_W-1:0] char_r;

  // Accept a new byte whenever the held one is empty or leaves this cycle.
  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r <= in_char_code;
    end
  end

  assign byte_valid = valid_r;
  assign byte_code  = char_r;

endmodule

FILE: src/dsu_parse_core.sv
// Parse state (phase, accumulator, position) and the per-byte decision logic.
// Depends on dsu_pkg for widths, character codes and the result struct.
`timescale 1ns / 1ps

module dsu_parse_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [dsu_pkg::CHAR_W-1:0] byte_code,
  output logic                       emit,
  output dsu_pkg::result_t           result
);

  localparam logic [1:0] PH_PREFIX  = 2'd0;
  localparam logic [1:0] PH_PLUS    = 2'd1;
  localparam logic [1:0] PH_DIGITS  = 2'd2;
  localparam logic [1:0] PH_SWALLOW = 2'd3;

  localparam int unsigned WIDE_W = dsu_pkg::VALUE_W + 4;

  logic [1:0]                  phase_r;
  logic [1:0]                  phase_nxt;
  logic [dsu_pkg::VALUE_W-1:0] acc_r;
  logic [dsu_pkg::VALUE_W-1:0] acc_nxt;
  logic [dsu_pkg::POS_W-1:0]   pos_r;
  logic [dsu_pkg::POS_W-1:0]   pos_nxt;

  logic                        is_nul;
  logic                        is_digit;
  logic [WIDE_W-1:0]           acc_x10;
  logic                        mul_ovf;
  logic [dsu_pkg::POS_W-1:0]   pos_adv;

  assign is_nul   = (byte_code == dsu_pkg::CH_NUL);
  assign is_digit = (byte_code >= dsu_pkg::CH_ZERO) && (byte_code <= dsu_pkg::CH_NINE);

  // acc * 10 + digit as (acc << 3) + (acc << 1) + digit; any carry above 64 bits overflows.
  assign acc_x10 = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                 + {{(WIDE_W-4){1'b0}}, byte_code[3:0]};
  assign mul_ovf = |acc_x10[WIDE_W-1:dsu_pkg::VALUE_W];

  assign pos_adv = (pos_r < dsu_pkg::POS_LIMIT) ?
                   pos_r + {{(dsu_pkg::POS_W-1){1'b0}}, 1'b1} : pos_r;

  always_comb begin
    phase_nxt      = phase_r;
    acc_nxt        = acc_r;
    pos_nxt        = pos_r;
    emit           = 1'b0;
    result         = '0;

    case (phase_r)
      PH_PREFIX, PH_PLUS, PH_DIGITS: begin
        if (is_digit && (phase_r != PH_PLUS || is_digit)) begin
          if (mul_ovf) begin
            emit            = 1'b1;
            result.value    = '1;
            result.end_pos  = pos_r;
            result.overflow = 1'b1;
          end else begin
            acc_nxt   = acc_x10[dsu_pkg::VALUE_W-1:0];
            pos_nxt   = pos_adv;
            phase_nxt = PH_DIGITS;
          end
        end else if (phase_r == PH_DIGITS) begin
          emit           = 1'b1;
          result.value   = acc_r;
          result.end_pos = pos_r;
        end else if (phase_r == PH_PLUS) begin
          emit = 1'b1;
        end else if (is_nul || byte_code == dsu_pkg::CH_MINUS) begin
          emit           = 1'b1;
          result.end_pos = pos_r;
        end else if (byte_code == dsu_pkg::CH_SPACE) begin
          pos_nxt = pos_adv;
        end else if (byte_code == dsu_pkg::CH_PLUS) begin
          pos_nxt   = pos_adv;
          phase_nxt = PH_PLUS;
        end else begin
          emit = 1'b1;
        end
      end
      PH_SWALLOW: begin
        if (is_nul) begin
          phase_nxt = PH_PREFIX;
          acc_nxt   = '0;
          pos_nxt   = '0;
        end
      end
      default: begin
        phase_nxt = PH_PREFIX;
      end
    endcase

    // A decided string either ends here or swallows its tail.
    if (emit) begin
      if (is_nul) begin
        phase_nxt = PH_PREFIX;
        acc_nxt   = '0;
        pos_nxt   = '0;
      end else begin
        phase_nxt = PH_SWALLOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREFIX;
      acc_r   <= '0;
      pos_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

FILE: src/dsu_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
// Depends on dsu_pkg for the result struct.
`timescale 1ns / 1ps

module dsu_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  dsu_pkg::result_t load_data,
  output logic             out_valid,
  input  logic             out_ready,
  output dsu_pkg::result_t out_data
);

  logic             valid_r;
  logic             valid_nxt;
  dsu_pkg::result_t data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: src/decimal_string_to_u64_unit.sv
// Streaming unsigned decimal parser: one string byte per item, 64-bit result.
// A deciding byte's result reaches the out_ ports through the input register, then the
// result register. Throughput: 1 item per cycle while the result register is empty or
// being drained, set by the combinational multiply-by-ten and add.
// Reset: synchronous active-low rst_n empties both registers and returns the
// parser to the start of a string (position 0, accumulator 0).
// Depends on dsu_pkg, dsu_in_reg, dsu_parse_core and dsu_out_reg.
`timescale 1ns / 1ps

module decimal_string_to_u64_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dsu_pkg::CHAR_W-1:0]  in_char_code,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dsu_pkg::VALUE_W-1:0] out_value,
  output logic [dsu_pkg::POS_W-1:0]   out_end_pos,
  output logic                        out_overflow_flag
);

  logic                       byte_valid;
  logic [dsu_pkg::CHAR_W-1:0] byte_code;
  logic                       step;
  logic                       emit;
  dsu_pkg::result_t           core_result;
  dsu_pkg::result_t           out_data;

  // Advance the parser on the held byte only when the result register can
  // take whatever it decides: empty, or being drained this same cycle.
  assign step = byte_valid && (!out_valid || out_ready);

  dsu_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .take         (step),
    .byte_valid   (byte_valid),
    .byte_code    (byte_code)
  );

  // Phase, accumulator and position live here; a byte either updates them
  // silently or decides the string and produces one result.
  dsu_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .byte_code (byte_code),
    .emit      (emit),
    .result    (core_result)
  );

  // Hold the result until the consumer takes it.
  dsu_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && emit),
    .load_data (core_result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_value         = out_data.value;
  assign out_end_pos       = out_data.end_pos;
  assign out_overflow_flag = out_data.overflow;

`ifndef SYNTHESIS
  // Overflow always saturates the value.
  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow_flag |-> (&out_value))
    else $error("overflow result without all-ones value");

  // Overflow needs at least twenty digits, so the stop offset is at least 19.
  a_ovf_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow_flag |-> out_end_pos >= 16'd19)
    else $error("overflow reported too early in the string");

  // A nonzero value needs at least one consumed digit before the stop offset.
  a_value_needs_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_value != '0) |-> out_end_pos != '0)
    else $error("nonzero value at string offset zero");

  // No result appears unless the parser stepped on a byte in the cycle before.
  a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(step))
    else $error("result appeared without a parser step");
`endif

endmodule

FILE: test/tb_top.sv
// Testbench for decimal_string_to_u64_unit: streams strings one byte per item and checks
// every parse result against a parser model kept here. Depends on dsu_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_top;

  typedef logic [dsu_pkg::CHAR_W-1:0]  char_t;
  typedef logic [dsu_pkg::VALUE_W-1:0] value_t;
  typedef logic [dsu_pkg::POS_W-1:0]   pos_t;
  typedef char_t char_q_t[$];

  // Parser phases of the model: leading spaces, after '+', in digits, skipping the tail.
  typedef enum logic [1:0] {SCAN_LEAD, SCAN_SIGN, SCAN_DIGITS, SCAN_SKIP} scan_e;

  localparam value_t      ALL_ONES        = '1;
  localparam int unsigned ITEM_TARGET     = 450;
  localparam int unsigned LONG_SPACES     = 200;    // position stays within a byte's range
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned PRESSURE_STRS   = 40;
  localparam int unsigned SETTLE_CYCLES   = 8;      // settle time after the last expected result
  localparam int unsigned REPORT_LIMIT    = 10;

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  char_t   in_char_code;
  logic    out_valid;
  logic    out_ready;
  value_t  out_value;
  pos_t    out_end_pos;
  logic    out_overflow_flag;

  decimal_string_to_u64_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_code      (in_char_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_value         (out_value),
    .out_end_pos       (out_end_pos),
    .out_overflow_flag (out_overflow_flag)
  );

  // Model state, mirrors the parser after every accepted item.
  scan_e              scan_phase;
  value_t             digit_acc;
  pos_t               str_pos;
  dsu_pkg::result_t   expected_parses[$];

  int items_sent    = 0;
  int error_count   = 0;
  int hold_request  = 0;  // receiver picks this up and stalls that many cycles
  bit send_idle     = 1'b1;
  bit recv_idle     = 1'b1;

  // Clock and time limit
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------
  function automatic void restart_string();
    scan_phase = SCAN_LEAD;
    digit_acc  = '0;
    str_pos    = '0;
  endfunction

  // Position stops counting at the limit instead of wrapping.
  function automatic void bump_pos();
    if (str_pos < dsu_pkg::POS_LIMIT) str_pos++;
  endfunction

  function automatic bit is_digit(char_t c);
    return c >= dsu_pkg::CH_ZERO && c <= dsu_pkg::CH_NINE;
  endfunction

  // Record the single result of a string; a NUL ends the string, anything else
  // leaves the tail to be skipped up to the NUL.
  function automatic void close_string(value_t v, pos_t p, logic ovf, char_t c);
    dsu_pkg::result_t r;
    r.value    = v;
    r.end_pos  = p;
    r.overflow = ovf;
    expected_parses.push_back(r);
    if (c == dsu_pkg::CH_NUL) restart_string();
    else scan_phase = SCAN_SKIP;
  endfunction

  // One byte in the digit phase: stop, overflow, or accumulate.
  function automatic void take_digit(char_t c);
    value_t d;
    d = value_t'(c) - value_t'(dsu_pkg::CH_ZERO);
    if (!is_digit(c)) close_string(digit_acc, str_pos, 1'b0, c);
    else if ((ALL_ONES - d) / 10 < digit_acc) close_string(ALL_ONES, str_pos, 1'b1, c);
    else begin
      digit_acc = digit_acc * 10 + d;
      bump_pos();
    end
  endfunction

  function automatic void parse_byte(char_t c);
    case (scan_phase)
      SCAN_LEAD: begin
        if (c == dsu_pkg::CH_NUL || c == dsu_pkg::CH_MINUS) close_string('0, str_pos, 1'b0, c);
        else if (c == dsu_pkg::CH_SPACE) bump_pos();
        else if (c == dsu_pkg::CH_PLUS) begin
          bump_pos();
          scan_phase = SCAN_SIGN;
        end else if (is_digit(c)) begin
          scan_phase = SCAN_DIGITS;
          take_digit(c);
        end else close_string('0, '0, 1'b0, c);
      end
      SCAN_SIGN: begin
        if (is_digit(c)) begin
          scan_phase = SCAN_DIGITS;
          take_digit(c);
        end else close_string('0, '0, 1'b0, c);
      end
      SCAN_DIGITS: take_digit(c);
      default: begin
        if (c == dsu_pkg::CH_NUL) restart_string();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: compare each accepted result with the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    dsu_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_parses.size() == 0) begin
        note_error($sformatf("unexpected result value=%0d end_pos=%0d overflow=%0b",
                             out_value, out_end_pos, out_overflow_flag));
      end else begin
        want = expected_parses.pop_front();
        if (out_value !== want.value)
          note_error($sformatf("value: expected %0d, got %0d", want.value, out_value));
        if (out_end_pos !== want.end_pos)
          note_error($sformatf("end_pos: expected %0d, got %0d", want.end_pos, out_end_pos));
        if (out_overflow_flag !== want.overflow)
          note_error($sformatf("overflow: expected %0b, got %0b", want.overflow,
                               out_overflow_flag));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request counted here.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else if (recv_idle) stall = pick_gap();
      else stall = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Offer one item; hold valid and payload until accepted, then advance the model.
  // Called right after a rising edge.
  task automatic send_char(input char_t c);
    int unsigned gap;
    gap = send_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_byte(c);
    items_sent++;
  endtask

  task automatic send_string(input char_q_t s);
    foreach (s[i]) send_char(s[i]);
  endtask

  // Bytes of a text followed by the terminating NUL.
  function automatic char_q_t with_nul(string t);
    char_q_t q;
    for (int i = 0; i < t.len(); i++) q.push_back(char_t'(t[i]));
    q.push_back(dsu_pkg::CH_NUL);
    return q;
  endfunction

  function automatic char_t rand_digit();
    return dsu_pkg::CH_ZERO + char_t'($urandom_range(0, 9));
  endfunction

  function automatic char_t rand_non_digit();
    char_t c;
    do c = char_t'($urandom_range(1, 255)); while (is_digit(c));
    return c;
  endfunction

  // Append a random tail of 0..3 bytes and the NUL.
  function automatic void add_tail(ref char_q_t q);
    repeat ($urandom_range(0, 3)) q.push_back(char_t'($urandom_range(1, 255)));
    q.push_back(dsu_pkg::CH_NUL);
  endfunction

  // Random string: mostly well-formed numbers, the rest rejects and noise.
  function automatic char_q_t make_string();
    char_q_t     q;
    int unsigned kind;
    int unsigned r;
    kind = $urandom_range(0, 99);
    repeat ($urandom_range(0, 99) < 80 ? $urandom_range(0, 2) : $urandom_range(3, 9))
      q.push_back(dsu_pkg::CH_SPACE);
    if (kind < 70) begin
      if ($urandom_range(0, 99) < 30) q.push_back(dsu_pkg::CH_PLUS);
      r = $urandom_range(0, 99);
      if (r < 80) repeat ($urandom_range(1, 6)) q.push_back(rand_digit());
      else if (r < 90) repeat ($urandom_range(7, 22)) q.push_back(rand_digit());
      else begin
        // Near the top of the range: the twentieth digit decides overflow.
        q = {q, with_nul("1844674407370955161")};
        q[q.size()-1] = rand_digit();
        if ($urandom_range(0, 1)) q.push_back(rand_digit());
      end
      if ($urandom_range(0, 1)) q.push_back(dsu_pkg::CH_NUL);
      else begin
        q.push_back(rand_non_digit());
        add_tail(q);
      end
    end else if (kind < 80) begin
      q.push_back(dsu_pkg::CH_MINUS);
      add_tail(q);
    end else if (kind < 90) begin
      q.push_back(dsu_pkg::CH_PLUS);
      if ($urandom_range(0, 1)) q.push_back(dsu_pkg::CH_NUL);
      else begin
        q.push_back(rand_non_digit());
        add_tail(q);
      end
    end else begin
      repeat ($urandom_range(1, 8)) q.push_back(char_t'($urandom_range(0, 255)));
      q.push_back(dsu_pkg::CH_NUL);
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Prefix handling: empty, spaces only, minus, bare plus, plus then junk,
  // leading junk, top byte value, digits stopped by a non-digit, space then plus then digit.
  task automatic test_prefix_cases();
    send_string(with_nul(""));
    send_string(with_nul("   "));
    send_string(with_nul("  -7"));
    send_string(with_nul("+"));
    send_string(with_nul("+x9"));
    send_string(with_nul("x12"));
    send_string({8'hFF, dsu_pkg::CH_NUL});
    send_string(with_nul("42a7"));
    send_string(with_nul(" +9"));
  endtask

  // Value range: zero, the largest value, and one past it.
  task automatic test_value_extremes();
    send_string(with_nul("0"));
    send_string(with_nul("18446744073709551615"));
    send_string(with_nul("18446744073709551616"));
  endtask

  // A long run of leading spaces before two digits; end_pos ends at 202.
  task automatic test_long_string();
    char_q_t q;
    repeat (LONG_SPACES) q.push_back(dsu_pkg::CH_SPACE);
    q = {q, with_nul("12")};
    send_idle = 1'b0;
    send_string(q);
    send_idle = 1'b1;
  endtask

  // Hold the receiver off while short strings keep coming, so the unit backs up.
  task automatic test_output_backpressure();
    send_idle    = 1'b0;
    hold_request = HOLD_OFF_CYCLES;
    repeat (PRESSURE_STRS) send_string({rand_digit(), dsu_pkg::CH_NUL});
    send_idle = 1'b1;
  endtask

  // Random strings with mixed idling; some strings run with no gaps at all.
  task automatic test_random_strings();
    int start_count;
    bit busy;
    start_count = items_sent;
    while (items_sent - start_count < ITEM_TARGET) begin
      busy      = $urandom_range(0, 9) == 0;
      send_idle = !busy;
      recv_idle = !busy;
      send_string(make_string());
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // Main sequence
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_code = '0;
    restart_string();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_prefix_cases();
    test_value_extremes();
    test_long_string();
    test_output_backpressure();
    test_random_strings();

    // Drain: wait for every expected result, then a settle time for strays.
    in_valid <= 1'b0;
    while (expected_parses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
